### hw/rtl/gprb_pkg.sv
// shared types and constants of the gpio port register block
`default_nettype none

package gprb_pkg;

	// pin slots covered by the internal padded vectors
	localparam int unsigned PIN_SLOTS     = 64;
	localparam int unsigned BANK_BITS     = 32;
	localparam int unsigned FSEL_PER_WORD = 10;
	localparam int unsigned FSEL_PINS     = 60;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} opcode_t;

	// register word offsets
	localparam logic [5:0] W_FSEL_LAST = 6'd5;
	localparam logic [5:0] W_SET0      = 6'd7;
	localparam logic [5:0] W_SET1      = 6'd8;
	localparam logic [5:0] W_CLR0      = 6'd10;
	localparam logic [5:0] W_CLR1      = 6'd11;
	localparam logic [5:0] W_LEV0      = 6'd13;
	localparam logic [5:0] W_LEV1      = 6'd14;
	localparam logic [5:0] W_PUD       = 6'd37;
	localparam logic [5:0] W_PUDCLK0   = 6'd38;
	localparam logic [5:0] W_PUDCLK1   = 6'd39;

	localparam logic [2:0] FSEL_OUTPUT = 3'd1;
	localparam logic [1:0] PULL_DOWN   = 2'd1;
	localparam logic [1:0] PULL_UP     = 2'd2;

	// decoded register access
	typedef struct packed {
		logic       write;
		logic       fsel;
		logic [2:0] fsel_word;
		logic       lev;
		logic       pud;
		logic       set;
		logic       clr;
		logic       pudclk;
		logic       bank;
	} access_t;

endpackage

`default_nettype wire

### hw/rtl/gprb_decode.sv
// register word offset decoder
`default_nettype none

module gprb_decode (
	input  wire logic            opcode,
	input  wire logic [5:0]      word_index,
	output gprb_pkg::access_t    acc
);
	import gprb_pkg::*;

	always_comb begin
		acc           = '0;
		acc.write     = (opcode == OP_WRITE);
		acc.fsel      = (word_index <= W_FSEL_LAST);
		acc.fsel_word = word_index[2:0];
		acc.lev       = (word_index == W_LEV0) || (word_index == W_LEV1);
		acc.pud       = (word_index == W_PUD);
		acc.set       = (word_index == W_SET0) || (word_index == W_SET1);
		acc.clr       = (word_index == W_CLR0) || (word_index == W_CLR1);
		acc.pudclk    = (word_index == W_PUDCLK0) || (word_index == W_PUDCLK1);
		// upper bank: pins 32 and above
		acc.bank      = (word_index == W_SET1) || (word_index == W_CLR1) ||
		                (word_index == W_LEV1) || (word_index == W_PUDCLK1);
	end

endmodule

`default_nettype wire

### hw/rtl/gpio_port_register_block_core.sv
// top level of the gpio port register block: access pipeline, pin state, results
//
// channel | direction | handshake            | payload
// --------+-----------+----------------------+------------------------------------------
// in      | into core | in_valid / in_stall   | opcode, word_index, write_data, pins_in_*
// out     | from core | out_valid / out_stall | read_data, drive_*, enable_*, pull*_*
//
// one access per cycle sustained while no result is held by out_stall; a transferred
// access passes the input register, then the state update and read data register,
// before its result is offered
// reset clears the pipeline valids, function codes, output latch and pull state
// the drive, enable and pull outputs come straight from the pin state, which only
// changes when a result moves forward, so a stalled result holds all its fields
// in_stall rises only when the input register is full and cannot move on
`default_nettype none

module gpio_port_register_block_core #(
	parameter int unsigned PIN_COUNT = 54
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [5:0]  word_index,
	input  wire logic [31:0] write_data,
	input  wire logic [31:0] pins_in_low,
	input  wire logic [21:0] pins_in_high,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      read_data,
	output logic [31:0]      drive_low,
	output logic [21:0]      drive_high,
	output logic [31:0]      enable_low,
	output logic [21:0]      enable_high,
	output logic [31:0]      pullup_low,
	output logic [21:0]      pullup_high,
	output logic [31:0]      pulldown_low,
	output logic [21:0]      pulldown_high
);
	import gprb_pkg::*;

	// pins that own a function-select slot
	localparam int unsigned FSEL_N = (PIN_COUNT < FSEL_PINS) ? PIN_COUNT : FSEL_PINS;

	// decode of the incoming access
	access_t acc_in;

	gprb_decode u_decode (
		.opcode     (opcode),
		.word_index (word_index),
		.acc        (acc_in)
	);

	// input register
	logic        s1_valid_s1;
	access_t     acc_s1;
	logic [31:0] wdata_s1;
	logic [31:0] pins_lo_s1;
	logic [21:0] pins_hi_s1;

	// result register
	logic        out_valid_q;
	logic [31:0] rd_q;

	// pin state
	logic [2:0]           fsel_q  [FSEL_N];
	logic [1:0]           pull_q  [PIN_COUNT];
	logic [PIN_COUNT-1:0] latch_q;
	logic [1:0]           mode_q;

	// padded views of the pin state, zero beyond the pin count
	logic [2:0]           fsel_pad [PIN_SLOTS];
	logic [1:0]           pull_pad [PIN_SLOTS];
	logic [PIN_SLOTS-1:0] latch_pad;
	logic [PIN_SLOTS-1:0] pin_mask;
	logic [PIN_SLOTS-1:0] lev_pad;
	logic [PIN_SLOTS-1:0] lvl_pad;
	logic [PIN_SLOTS-1:0] en_pad;
	logic [PIN_SLOTS-1:0] pu_pad;
	logic [PIN_SLOTS-1:0] pd_pad;

	logic        adv;
	logic        in_xfer;
	logic        fsel_we;
	logic        set_we;
	logic        clr_we;
	logic        pudclk_we;
	logic        pud_we;
	logic [31:0] rd_fsel;
	logic [31:0] rd_nx;

	// the input register moves on unless a finished result is held
	assign adv      = s1_valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = s1_valid_s1 && !adv;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= in_xfer || (s1_valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			acc_s1     <= acc_in;
			wdata_s1   <= write_data;
			pins_lo_s1 <= pins_in_low;
			pins_hi_s1 <= pins_in_high;
		end
	end

	// write strobes of the access that moves into the result stage
	assign fsel_we   = adv && acc_s1.write && acc_s1.fsel;
	assign set_we    = adv && acc_s1.write && acc_s1.set;
	assign clr_we    = adv && acc_s1.write && acc_s1.clr;
	assign pudclk_we = adv && acc_s1.write && acc_s1.pudclk;
	assign pud_we    = adv && acc_s1.write && acc_s1.pud;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
		end else if (pud_we) begin
			mode_q <= wdata_s1[1:0];
		end
	end

	// per-pin state; pins without a select slot stay inputs
	for (genvar p = 0; p < PIN_SLOTS; p++) begin : g_pin
		if (p < FSEL_N) begin : g_fsel
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					fsel_q[p] <= '0;
				end else if (fsel_we && acc_s1.fsel_word == 3'(p / FSEL_PER_WORD)) begin
					fsel_q[p] <= wdata_s1[3*(p % FSEL_PER_WORD) +: 3];
				end
			end
			assign fsel_pad[p] = fsel_q[p];
		end else begin : g_no_fsel
			assign fsel_pad[p] = '0;
		end

		if (p < PIN_COUNT) begin : g_io
			logic hit;
			assign hit = (acc_s1.bank == 1'(p / BANK_BITS)) && wdata_s1[p % BANK_BITS];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					latch_q[p] <= 1'b0;
				end else if (set_we && hit) begin
					latch_q[p] <= 1'b1;
				end else if (clr_we && hit) begin
					latch_q[p] <= 1'b0;
				end
			end

			// pull clock copies the stored mode into the selected pins
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pull_q[p] <= '0;
				end else if (pudclk_we && hit) begin
					pull_q[p] <= mode_q;
				end
			end

			assign latch_pad[p] = latch_q[p];
			assign pull_pad[p]  = pull_q[p];
			assign pin_mask[p]  = 1'b1;
		end else begin : g_no_io
			assign latch_pad[p] = 1'b0;
			assign pull_pad[p]  = '0;
			assign pin_mask[p]  = 1'b0;
		end
	end

	// external levels exist for the first 54 pins only
	assign lev_pad = PIN_SLOTS'({pins_hi_s1, pins_lo_s1});

	always_comb begin
		for (int p = 0; p < PIN_SLOTS; p++) begin
			en_pad[p]  = (fsel_pad[p] == FSEL_OUTPUT);
			pu_pad[p]  = (pull_pad[p] == PULL_UP);
			pd_pad[p]  = (pull_pad[p] == PULL_DOWN);
			lvl_pad[p] = pin_mask[p] && (en_pad[p] ? latch_pad[p] : lev_pad[p]);
		end
	end

	// ten codes of the addressed select word, top two bits zero
	always_comb begin
		logic [5:0] idx;
		rd_fsel = '0;
		for (int b = 0; b < FSEL_PER_WORD; b++) begin
			idx = 6'(int'(acc_s1.fsel_word) * FSEL_PER_WORD + b);
			rd_fsel[3*b +: 3] = fsel_pad[idx];
		end
	end

	always_comb begin
		rd_nx = '0;
		if (!acc_s1.write) begin
			priority if (acc_s1.fsel) begin
				rd_nx = rd_fsel;
			end else if (acc_s1.lev) begin
				rd_nx = acc_s1.bank ? lvl_pad[63:32] : lvl_pad[31:0];
			end else if (acc_s1.pud) begin
				rd_nx = 32'(mode_q);
			end else begin
				rd_nx = '0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q <= rd_nx;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = rd_q;
	assign drive_low     = latch_pad[31:0];
	assign drive_high    = latch_pad[53:32];
	assign enable_low    = en_pad[31:0];
	assign enable_high   = en_pad[53:32];
	assign pullup_low    = pu_pad[31:0];
	assign pullup_high   = pu_pad[53:32];
	assign pulldown_low  = pd_pad[31:0];
	assign pulldown_high = pd_pad[53:32];

	// stall back only while the input register holds an access
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_s1)
		else $error("input stall without a held access");

	// a held result keeps its read data, drive outputs, low enables and low pull-ups
	a_state_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> ($stable(drive_low) && $stable(drive_high) &&
		$stable(enable_low) && $stable(pullup_low) && $stable(read_data)))
		else $error("pin state changed under a held result");

	// writes return zero read data
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && acc_s1.write) |=> (read_data == '0))
		else $error("write returned non-zero read data");

	// a pin never pulls both ways
	a_pull_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		((pullup_low & pulldown_low) == '0) && ((pullup_high & pulldown_high) == '0))
		else $error("pull-up and pull-down both active");

	// an access that cannot move on stays in the input register
	a_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !adv) |=> s1_valid_s1)
		else $error("stalled access lost");

endmodule

`default_nettype wire

### sim/gpio_port_register_block_core_tb.sv
// self-checking testbench of the gpio port register block: directed and random bus accesses
module gpio_port_register_block_core_tb;
	import gprb_pkg::*;

	localparam int unsigned PIN_COUNT = 54;
	// offsets that decode to nothing
	localparam logic [5:0] W_UNUSED_GAP = 6'd6;
	localparam logic [5:0] W_UNUSED_TOP = 6'd63;
	// one function code of output in each of the ten slots of a select word
	localparam logic [31:0] FSEL_ALL_OUTPUT = 32'h0924_9249;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 6;

	// everything one result transfer carries
	typedef struct packed {
		logic [31:0] read_data;
		logic [31:0] drive_low;
		logic [21:0] drive_high;
		logic [31:0] enable_low;
		logic [21:0] enable_high;
		logic [31:0] pullup_low;
		logic [21:0] pullup_high;
		logic [31:0] pulldown_low;
		logic [21:0] pulldown_high;
	} pin_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OP_READ;
	logic [5:0]  word_index = '0;
	logic [31:0] write_data = '0;
	logic [31:0] pins_in_low = '0;
	logic [21:0] pins_in_high = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic [31:0] drive_low;
	logic [21:0] drive_high;
	logic [31:0] enable_low;
	logic [21:0] enable_high;
	logic [31:0] pullup_low;
	logic [21:0] pullup_high;
	logic [31:0] pulldown_low;
	logic [21:0] pulldown_high;

	// own copy of the pin controller state
	logic [2:0]  fn_code [PIN_COUNT];
	logic [63:0] pin_latch;
	logic [1:0]  pull_mode;
	logic [1:0]  pin_pull [PIN_COUNT];

	pin_state_t awaited_pin_states[$];

	int mismatches = 0;
	int results_checked = 0;
	int reads_sent = 0;
	int writes_sent = 0;
	int in_held_cycles = 0;
	int quiet_cycles = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit hold_req = 1'b0;

	gpio_port_register_block_core #(
		.PIN_COUNT(PIN_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.word_index(word_index),
		.write_data(write_data),
		.pins_in_low(pins_in_low),
		.pins_in_high(pins_in_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.drive_low(drive_low),
		.drive_high(drive_high),
		.enable_low(enable_low),
		.enable_high(enable_high),
		.pullup_low(pullup_low),
		.pullup_high(pullup_high),
		.pulldown_low(pulldown_low),
		.pulldown_high(pulldown_high)
	);

	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// state after reset, matching the block
	task automatic reset_pin_state();
		for (int p = 0; p < PIN_COUNT; p++) begin
			fn_code[p]  = '0;
			pin_pull[p] = '0;
		end
		pin_latch = '0;
		pull_mode = '0;
	endtask

	// one register access applied to the state, giving the result it must produce
	task automatic apply_register_access(input opcode_t op, input logic [5:0] idx,
			input logic [31:0] wd, input logic [63:0] lev, output pin_state_t res);
		int p;
		int base;
		logic [31:0] rd;
		logic [63:0] en, pu, pd;
		rd = '0;
		en = '0;
		pu = '0;
		pd = '0;
		if (idx <= W_FSEL_LAST) begin
			// ten slots per word, bits 30 and 31 unused
			for (int b = 0; b < 10; b++) begin
				p = int'(idx) * 10 + b;
				if (p < PIN_COUNT) begin
					if (op == OP_WRITE)
						fn_code[p] = wd[3*b +: 3];
					else
						rd[3*b +: 3] = fn_code[p];
				end
			end
		end else if (idx == W_LEV0 || idx == W_LEV1) begin
			if (op == OP_READ) begin
				base = (idx == W_LEV1) ? 32 : 0;
				for (int b = 0; b < 32; b++) begin
					p = base + b;
					if (p < PIN_COUNT)
						rd[b] = (fn_code[p] == FSEL_OUTPUT) ? pin_latch[p] : lev[p];
				end
			end
		end else if (idx == W_PUD) begin
			if (op == OP_WRITE)
				pull_mode = wd[1:0];
			else
				rd = {30'b0, pull_mode};
		end else if (op == OP_WRITE && (idx == W_SET0 || idx == W_SET1 || idx == W_CLR0 ||
				idx == W_CLR1 || idx == W_PUDCLK0 || idx == W_PUDCLK1)) begin
			base = (idx == W_SET1 || idx == W_CLR1 || idx == W_PUDCLK1) ? 32 : 0;
			for (int b = 0; b < 32; b++) begin
				p = base + b;
				if (p < PIN_COUNT && wd[b]) begin
					if (idx == W_SET0 || idx == W_SET1)
						pin_latch[p] = 1'b1;
					else if (idx == W_CLR0 || idx == W_CLR1)
						pin_latch[p] = 1'b0;
					else
						pin_pull[p] = pull_mode;
				end
			end
		end
		for (int q = 0; q < PIN_COUNT; q++) begin
			en[q] = (fn_code[q] == FSEL_OUTPUT);
			pu[q] = (pin_pull[q] == PULL_UP);
			pd[q] = (pin_pull[q] == PULL_DOWN);
		end
		res.read_data     = (op == OP_WRITE) ? 32'd0 : rd;
		res.drive_low     = pin_latch[31:0];
		res.drive_high    = pin_latch[53:32];
		res.enable_low    = en[31:0];
		res.enable_high   = en[53:32];
		res.pullup_low    = pu[31:0];
		res.pullup_high   = pu[53:32];
		res.pulldown_low  = pd[31:0];
		res.pulldown_high = pd[53:32];
	endtask

	// offers one access, holds it until the transfer, then records what it must give
	task automatic send_access(input opcode_t op, input logic [5:0] idx, input logic [31:0] wd,
			input logic [31:0] lev_lo, input logic [21:0] lev_hi);
		int gap;
		pin_state_t res;
		gap = tx_idle ? pick_gap() : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		opcode       <= op;
		word_index   <= idx;
		write_data   <= wd;
		pins_in_low  <= lev_lo;
		pins_in_high <= lev_hi;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		apply_register_access(op, idx, wd, {10'b0, lev_hi, lev_lo}, res);
		awaited_pin_states.push_back(res);
		if (op == OP_WRITE)
			writes_sent++;
		else
			reads_sent++;
	endtask

	// mostly decoded words, the rest anywhere in the offset range
	function automatic logic [5:0] pick_word();
		logic [5:0] w;
		case ($urandom_range(0, 12))
			0, 1, 2: w = 6'($urandom_range(0, W_FSEL_LAST));
			3:       w = W_SET0;
			4:       w = W_SET1;
			5:       w = W_CLR0;
			6:       w = W_CLR1;
			7:       w = W_LEV0;
			8:       w = W_LEV1;
			9:       w = W_PUD;
			10:      w = W_PUDCLK0;
			11:      w = W_PUDCLK1;
			default: w = 6'($urandom_range(0, 63));
		endcase
		return w;
	endfunction

	// select word with many output codes, so that level reads see the latch
	function automatic logic [31:0] fsel_word_data();
		logic [31:0] d;
		d = $urandom();
		for (int k = 0; k < 10; k++)
			if ($urandom_range(0, 2) == 0)
				d[3*k +: 3] = FSEL_OUTPUT;
		return d;
	endfunction

	task automatic send_random_access();
		opcode_t op;
		logic [5:0] w;
		logic [31:0] d, lo;
		logic [21:0] hi;
		op = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
		w = pick_word();
		case ($urandom_range(0, 7))
			0:       d = '0;
			1:       d = '1;
			2:       d = 32'd1 << $urandom_range(0, 31);
			default: d = $urandom();
		endcase
		if (op == OP_WRITE && w <= W_FSEL_LAST && $urandom_range(0, 1))
			d = fsel_word_data();
		lo = $urandom();
		hi = 22'($urandom());
		case ($urandom_range(0, 9))
			0: begin
				lo = '0;
				hi = '0;
			end
			1: begin
				lo = '1;
				hi = '1;
			end
			default: ;
		endcase
		send_access(op, w, d, lo, hi);
	endtask

	// register contents straight out of reset
	task automatic test_reset_state();
		send_access(OP_READ, 6'd0, '0, '0, '0);
		send_access(OP_READ, W_FSEL_LAST, '0, '0, '0);
		send_access(OP_READ, W_LEV0, '0, '1, '1);
		send_access(OP_READ, W_LEV1, '0, '1, '1);
		send_access(OP_READ, W_PUD, '0, '0, '0);
	endtask

	// unused top bits and the pins past the last one
	task automatic test_function_select();
		send_access(OP_WRITE, 6'd0, '1, '0, '0);
		send_access(OP_READ, 6'd0, '0, '0, '0);
		send_access(OP_WRITE, W_FSEL_LAST, '1, '0, '0);
		send_access(OP_READ, W_FSEL_LAST, '0, '0, '0);
		send_access(OP_WRITE, W_FSEL_LAST, FSEL_ALL_OUTPUT, '0, '0);
		send_access(OP_WRITE, 6'd0, FSEL_ALL_OUTPUT, '0, '0);
	endtask

	// set and clear banks, level reads mixing latch and external levels
	task automatic test_output_latch();
		send_access(OP_WRITE, W_SET0, '1, '0, '0);
		send_access(OP_WRITE, W_SET1, '1, '0, '0);
		send_access(OP_READ, W_LEV0, '0, '0, '0);
		send_access(OP_READ, W_LEV1, '0, '0, '0);
		send_access(OP_WRITE, W_CLR0, 32'hAAAA_AAAA, '1, '1);
		send_access(OP_WRITE, W_CLR1, '1, '1, '1);
		send_access(OP_READ, W_LEV0, '0, '1, '1);
	endtask

	// reserved mode, up and down, write-only and unused words
	task automatic test_pull_control();
		send_access(OP_WRITE, W_PUD, '1, '0, '0);
		send_access(OP_READ, W_PUD, '0, '0, '0);
		send_access(OP_WRITE, W_PUDCLK0, '1, '0, '0);
		send_access(OP_WRITE, W_PUD, 32'd2, '0, '0);
		send_access(OP_WRITE, W_PUDCLK1, '1, '0, '0);
		send_access(OP_WRITE, W_PUD, 32'd1, '0, '0);
		send_access(OP_WRITE, W_PUDCLK0, 32'h5555_5555, '0, '0);
		send_access(OP_READ, W_PUDCLK0, '0, '0, '0);
		send_access(OP_READ, W_UNUSED_GAP, '0, '1, '1);
		send_access(OP_WRITE, W_UNUSED_TOP, '1, '1, '1);
		send_access(OP_READ, W_UNUSED_TOP, '0, '1, '1);
	endtask

	task automatic test_random_accesses(input int count);
		repeat (count)
			send_random_access();
	endtask

	// neither side idles
	task automatic test_back_to_back(input int count);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		repeat (count)
			send_random_access();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// receiver holds off long enough for the pipeline to fill and push back
	task automatic test_input_backpressure(input int count);
		hold_req = 1'b1;
		tx_idle  = 1'b0;
		repeat (count)
			send_random_access();
		tx_idle = 1'b1;
	endtask

	task automatic compare_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			if (mismatches < 10)
				$display("mismatch in %s of result %0d: expected %h, got %h",
					field, results_checked, want, got);
			mismatches++;
		end
	endtask

	// receiver: random stall stretches, plus one long hold-off when asked
	initial begin : receiver
		int hold_left;
		int phase_left;
		hold_left  = 0;
		phase_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (phase_left != 0) begin
				phase_left--;
			end else if (rx_idle && $urandom_range(0, 2) == 0) begin
				out_stall  <= 1'b1;
				phase_left = pick_gap();
			end else begin
				out_stall  <= 1'b0;
				phase_left = $urandom_range(0, 6);
			end
		end
	end

	// result checker: each result transfer against the oldest awaited state
	always @(posedge clk) begin
		pin_state_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_pin_states.size() == 0) begin
				if (mismatches < 10)
					$display("result transfer with nothing awaited, read_data %h", read_data);
				mismatches++;
			end else begin
				want = awaited_pin_states.pop_front();
				compare_field("read_data", want.read_data, read_data);
				compare_field("drive_low", want.drive_low, drive_low);
				compare_field("drive_high", {10'b0, want.drive_high}, {10'b0, drive_high});
				compare_field("enable_low", want.enable_low, enable_low);
				compare_field("enable_high", {10'b0, want.enable_high}, {10'b0, enable_high});
				compare_field("pullup_low", want.pullup_low, pullup_low);
				compare_field("pullup_high", {10'b0, want.pullup_high}, {10'b0, pullup_high});
				compare_field("pulldown_low", want.pulldown_low, pulldown_low);
				compare_field("pulldown_high", {10'b0, want.pulldown_high},
					{10'b0, pulldown_high});
			end
			results_checked++;
		end
	end

	// watchdog: cycles in which no transfer happens on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_stall)
				in_held_cycles++;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("no transfer for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, awaited_pin_states.size());
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		reset_pin_state();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_function_select();
		test_output_latch();
		test_pull_control();
		test_random_accesses(700);
		test_back_to_back(300);
		test_input_backpressure(40);
		test_random_accesses(560);

		in_valid <= 1'b0;
		while (awaited_pin_states.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d reads and %0d writes over the whole offset range, %0d results checked",
			reads_sent, writes_sent, results_checked);
		$display("input held off for %0d cycles by output back-pressure, %0d mismatches",
			in_held_cycles, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### files.f
hw/rtl/gprb_pkg.sv
hw/rtl/gprb_decode.sv
hw/rtl/gpio_port_register_block_core.sv
sim/gpio_port_register_block_core_tb.sv
